// ----- design/bblc_pkg.sv -----
// Package for the clamped line box blur: sizes, reciprocal scaling,
// controller states and the lane control bundle.
// No dependencies.
package bblc_pkg;

  // block limits
  localparam int MAX_RADIUS = 63;
  localparam int MAX_LINE   = 16384;

  // field and state widths
  localparam int RAD_W   = 6;
  localparam int CH_W    = 8;
  localparam int N_CH    = 4;
  localparam int PIX_W   = N_CH * CH_W;
  localparam int POS_W   = $clog2(MAX_LINE);
  // position of a step, including the flush steps past the last pixel
  localparam int Q_W     = POS_W + 1;
  // bits of the window length 2r+1, also the ring address width
  localparam int DIV_W   = $clog2(2 * MAX_RADIUS + 2);
  localparam int RING_AW = DIV_W;
  localparam int SUM_W   = $clog2((2 * MAX_RADIUS + 1) * ((1 << CH_W) - 1) + 1);

  // reciprocal 2^RCP_K / (2r+1), rounded up, is exact for every window sum
  localparam int RCP_K = SUM_W + DIV_W;
  localparam int RCP_W = RCP_K + 1;
  localparam int PRD_W = SUM_W + RCP_W;

  // controller states
  typedef enum logic {
    ST_RUN,
    ST_FLUSH
  } st_t;

  // control from the sequencer to every channel lane
  typedef struct packed {
    logic adv;     // output pipeline moves
    logic step;    // one window step happens
    logic init;    // first pixel of a line: load the window
    logic bypass;  // radius 0: window is the added pixel alone
  } lane_ctl_t;

endpackage

// ----- design/bblc_recip.sv -----
// Reciprocal table for the window length 2r+1, one entry per radius.
// Depends on bblc_pkg.
module bblc_recip (
  input  logic [bblc_pkg::RAD_W-1:0] rad,
  output logic [bblc_pkg::RCP_W-1:0] recip
);

  logic [bblc_pkg::RCP_W-1:0] tab [bblc_pkg::MAX_RADIUS+1];

  // entries worked out at elaboration
  for (genvar i = 0; i <= bblc_pkg::MAX_RADIUS; i++) begin : g_tab
    localparam logic [63:0] RC = ((64'd1 << bblc_pkg::RCP_K) + 64'(2 * i)) / 64'(2 * i + 1);
    assign tab[i] = bblc_pkg::RCP_W'(RC);
  end

  assign recip = tab[rad];

endmodule

// ----- design/bblc_lane.sv -----
// One channel lane: running window sum and the mean by reciprocal multiply.
// Depends on bblc_pkg.
module bblc_lane (
  input  logic                        clk,
  input  bblc_pkg::lane_ctl_t         ctl,
  input  logic [bblc_pkg::CH_W-1:0]   add_px,
  input  logic [bblc_pkg::CH_W-1:0]   sub_px,
  input  logic [bblc_pkg::RAD_W-1:0]  rad,
  input  logic [bblc_pkg::RCP_W-1:0]  recip,
  output logic [bblc_pkg::CH_W-1:0]   mean
);

  logic [bblc_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [bblc_pkg::PRD_W-1:0] prod_r;
  logic [bblc_pkg::DIV_W-1:0] win_len;

  assign win_len = {rad, 1'b1};

  // next window sum: load, pass or slide by one position
  always_comb begin
    if (ctl.init) begin
      sum_nxt = bblc_pkg::SUM_W'(win_len) * bblc_pkg::SUM_W'(add_px);
    end else if (ctl.bypass) begin
      sum_nxt = bblc_pkg::SUM_W'(add_px);
    end else begin
      sum_nxt = sum_r + bblc_pkg::SUM_W'(add_px) - bblc_pkg::SUM_W'(sub_px);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      sum_r <= sum_nxt;
    end
  end

  // scaled product, then the top bits are the truncated mean
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      prod_r <= bblc_pkg::PRD_W'(sum_r) * bblc_pkg::PRD_W'(recip);
    end
  end

  assign mean = prod_r[bblc_pkg::RCP_K +: bblc_pkg::CH_W];

endmodule

// ----- design/box_blur_line_clamped.sv -----
// Box blur along a line of B,G,R,A pixels with clamp to edge: four channel lanes keep
// running window sums and divide by 2r+1 through a reciprocal multiply. A pixel is taken
// each cycle while the output side keeps up; output x passes through the window sum, the
// product and the output register after the transfer of pixel x+r. The last pixel of a line
// (tlast, or position MAX_LINE-1) starts a flush of r more steps, during which no input is
// taken. The radius written on cfg_wr_data takes effect at the first pixel of the next line.
module box_blur_line_clamped (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,   // blur_radius
  // pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // in_blue, in_green, in_red, in_alpha
  input  logic        in_tlast,      // in_line_end
  // blurred output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // out_blue, out_green, out_red, out_alpha
  output logic        out_tlast      // out_line_end
);

  localparam int CW = bblc_pkg::CH_W;

  bblc_pkg::st_t                  state_r, state_nxt;
  logic [bblc_pkg::RAD_W-1:0]     blur_r, rad_r, rad_sat, rad_cur, rad_nxt;
  logic [bblc_pkg::PIX_W-1:0]     first_r, last_r, add_pix, sub_pix, rd_data_r;
  logic [bblc_pkg::Q_W-1:0]       q_r, q_nxt, endq_r;
  logic [bblc_pkg::RING_AW-1:0]   rd_addr;
  logic [bblc_pkg::PIX_W-1:0]     ring [2**bblc_pkg::RING_AW];
  logic [bblc_pkg::RCP_W-1:0]     recip;
  logic [bblc_pkg::CH_W-1:0]      mean [bblc_pkg::N_CH];
  logic                           adv, step, is_first, line_end_in, sub_neg;
  logic                           emit, emit_end, q_done;
  logic                           v1_r, v2_r, e1_r, e2_r, out_valid_r, out_last_r;
  logic [bblc_pkg::PIX_W-1:0]     out_data_r;
  bblc_pkg::lane_ctl_t            ctl;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blur_r <= bblc_pkg::RAD_W'(1);
    end else if (cfg_wr_en) begin
      blur_r <= cfg_wr_data;
    end
  end

  assign rad_sat = (blur_r > bblc_pkg::RAD_W'(bblc_pkg::MAX_RADIUS))
                 ? bblc_pkg::RAD_W'(bblc_pkg::MAX_RADIUS) : blur_r;

  // step conditions
  assign adv         = !out_valid_r || out_tready;
  assign is_first    = (q_r == '0);
  assign line_end_in = in_tlast || (q_r == bblc_pkg::Q_W'(bblc_pkg::MAX_LINE - 1));
  assign q_done      = (q_r == endq_r);
  assign rad_cur     = (state_r == bblc_pkg::ST_RUN && is_first) ? rad_sat : rad_r;
  // position leaving the window lies before the line start
  assign sub_neg     = (q_r <= bblc_pkg::Q_W'({rad_r, 1'b0}));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bblc_pkg::ST_RUN: begin
        if (step && line_end_in && rad_cur != '0) begin
          state_nxt = bblc_pkg::ST_FLUSH;
        end
      end
      bblc_pkg::ST_FLUSH: begin
        if (step && q_done) begin
          state_nxt = bblc_pkg::ST_RUN;
        end
      end
      default: state_nxt = bblc_pkg::ST_RUN;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    step      = 1'b0;
    emit_end  = 1'b0;
    add_pix   = last_r;
    case (state_r)
      bblc_pkg::ST_RUN: begin
        in_tready = adv;
        step      = adv && in_tvalid;
        emit_end  = line_end_in && (rad_cur == '0);
        add_pix   = in_tdata;
      end
      bblc_pkg::ST_FLUSH: begin
        step     = adv;
        emit_end = q_done;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign emit    = step && (q_r >= bblc_pkg::Q_W'(rad_cur));
  assign sub_pix = sub_neg ? first_r : rd_data_r;

  // next position and radius, used to prefetch the leaving pixel
  always_comb begin
    q_nxt   = q_r;
    rad_nxt = rad_r;
    if (step) begin
      if (state_r == bblc_pkg::ST_RUN) begin
        rad_nxt = rad_cur;
        q_nxt   = (line_end_in && rad_cur == '0) ? '0 : q_r + 1'b1;
      end else begin
        q_nxt = q_done ? '0 : q_r + 1'b1;
      end
    end
  end

  assign rd_addr = q_nxt[bblc_pkg::RING_AW-1:0] - {rad_nxt, 1'b0} - 1'b1;

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bblc_pkg::ST_RUN;
      q_r     <= '0;
      rad_r   <= bblc_pkg::RAD_W'(1);
      first_r <= '0;
      endq_r  <= '0;
    end else begin
      state_r <= state_nxt;
      q_r     <= q_nxt;
      rad_r   <= rad_nxt;
      if (step && state_r == bblc_pkg::ST_RUN) begin
        if (is_first) begin
          first_r <= in_tdata;
        end
        if (line_end_in) begin
          endq_r <= q_r + bblc_pkg::Q_W'(rad_cur);
        end
      end
    end
  end

  // last pixel repeats through the flush
  always_ff @(posedge clk) begin
    if (step && state_r == bblc_pkg::ST_RUN && line_end_in) begin
      last_r <= in_tdata;
    end
  end

  // pixel ring: write the accepted pixel, read the next leaving pixel
  always_ff @(posedge clk) begin
    if (step && state_r == bblc_pkg::ST_RUN) begin
      ring[q_r[bblc_pkg::RING_AW-1:0]] <= in_tdata;
    end
    rd_data_r <= ring[rd_addr];
  end

  // lane control
  always_comb begin
    ctl.adv    = adv;
    ctl.step   = step;
    ctl.init   = (state_r == bblc_pkg::ST_RUN) && is_first;
    ctl.bypass = (rad_cur == '0);
  end

  bblc_recip u_recip (
    .rad   (rad_r),
    .recip (recip)
  );

  // one lane per channel
  for (genvar c = 0; c < bblc_pkg::N_CH; c++) begin : g_lane
    bblc_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .add_px (add_pix[c*CW +: CW]),
      .sub_px (sub_pix[c*CW +: CW]),
      .rad    (rad_cur),
      .recip  (recip),
      .mean   (mean[c])
    );
  end

  // result valid pipeline alongside the lane stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= emit;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  // merge the lane means into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r       <= emit && emit_end;
      e2_r       <= e1_r;
      out_last_r <= e2_r;
      for (int c = 0; c < bblc_pkg::N_CH; c++) begin
        out_data_r[c*CW +: CW] <= mean[c];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule
